### rtl/lesq_pkg.sv
// Shared types and constants for the largest empty square scan.
// Used by lesq_line_buf, lesq_score and largest_empty_square_scan.
package lesq_pkg;

  // Map limits
  localparam int MAX_COLS  = 1024;
  localparam int MAX_ROWS  = 1024;
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);

  // Fixed field widths
  localparam int SCORE_W   = 11;
  localparam int POS_W     = 10;
  localparam int CHAR_W    = 8;
  localparam int CCOUNT_W  = 11;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  // Register map, one 32-bit register every 4 bytes
  localparam int PADDR_W = 3;
  localparam logic REG_COLUMN_COUNT  = 1'b0;
  localparam logic REG_OBSTACLE_CHAR = 1'b1;
  localparam logic [CCOUNT_W-1:0] COLUMN_COUNT_RST  = CCOUNT_W'(1024);
  localparam logic [CHAR_W-1:0]   OBSTACLE_CHAR_RST = CHAR_W'(111);

  // Input word
  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic              last_cell;
  } cell_word_t;

  // Result word
  typedef struct packed {
    logic [SCORE_W-1:0] best_size;
    logic [POS_W-1:0]   best_row;
    logic [POS_W-1:0]   best_col;
    logic               row_overflow;
  } result_word_t;

  // Cell as it enters the scoring stage
  typedef struct packed {
    logic               blocked;
    logic               last;
    logic [COL_W-1:0]   col;
    logic [POS_W-1:0]   row;
    logic               first_row;
    logic               row_sat;
    logic               col_wrap;
    logic               fwd_hit;
  } lesq_item_t;

  // Line buffer write port
  typedef struct packed {
    logic               en;
    logic [COL_W-1:0]   addr;
    logic [SCORE_W-1:0] data;
  } lesq_wr_t;

endpackage

### rtl/largest_empty_square_scan.sv
// Largest empty square scan: one map cell per cycle unless cell_ready holds it off,
// result word on the last cell. The last cell is registered into the scoring stage,
// which then loads the result register. Cells stall while a last cell is in the scoring
// stage or the result word waits. Line buffer: one read and one write a cycle.
// Reset (rst, synchronous): counters, best values and handshakes clear, registers
// return to 1024 columns and obstacle 111; the line buffer is not cleared.
module largest_empty_square_scan (
  input  logic                                clk,
  input  logic                                rst,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lesq_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  // cell stream
  input  logic                                cell_valid,
  output logic                                cell_ready,
  input  lesq_pkg::cell_word_t                cell_data,
  // result stream
  output logic                                result_valid,
  input  logic                                result_ready,
  output lesq_pkg::result_word_t              result
);

  logic [lesq_pkg::CCOUNT_W-1:0]  column_count;
  logic [lesq_pkg::CHAR_W-1:0]    obstacle_char;
  logic [lesq_pkg::COL_W-1:0]     col_pos;
  logic [lesq_pkg::ROW_CNT_W-1:0] row_pos;
  logic                           s1_valid;
  lesq_pkg::lesq_item_t           s1_item;
  logic [lesq_pkg::SCORE_W-1:0]   fwd_score;

  logic                           reg_sel;
  logic                           cfg_wr;
  logic                           accept;
  logic [lesq_pkg::CCOUNT_W-1:0]  cols_eff;
  logic                           row_sat;
  lesq_pkg::lesq_item_t           item_next;
  logic [lesq_pkg::SCORE_W-1:0]   up_mem;
  lesq_pkg::lesq_wr_t             wr;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= lesq_pkg::COLUMN_COUNT_RST;
      obstacle_char <= lesq_pkg::OBSTACLE_CHAR_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        lesq_pkg::REG_COLUMN_COUNT:  column_count  <= pwdata[lesq_pkg::CCOUNT_W-1:0];
        lesq_pkg::REG_OBSTACLE_CHAR: obstacle_char <= pwdata[lesq_pkg::CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      lesq_pkg::REG_COLUMN_COUNT:  prdata = 32'(column_count);
      lesq_pkg::REG_OBSTACLE_CHAR: prdata = 32'(obstacle_char);
      default:                     prdata = '0;
    endcase
  end

  // input handshake: hold off while the result register would be busy
  assign cell_ready = (!result_valid || result_ready) && !(s1_valid && s1_item.last);
  assign accept     = cell_valid && cell_ready;

  // clamp the column count into 1..MAX_COLS
  always_comb begin
    if (column_count == '0) begin
      cols_eff = lesq_pkg::CCOUNT_W'(1);
    end else if (column_count > lesq_pkg::CCOUNT_W'(lesq_pkg::MAX_COLS)) begin
      cols_eff = lesq_pkg::CCOUNT_W'(lesq_pkg::MAX_COLS);
    end else begin
      cols_eff = column_count;
    end
  end

  // position decode for the accepted cell
  always_comb begin
    row_sat             = row_pos >= lesq_pkg::ROW_CNT_W'(lesq_pkg::MAX_ROWS);
    item_next.blocked   = cell_data.cell_char == obstacle_char;
    item_next.last      = cell_data.last_cell;
    item_next.col       = col_pos;
    item_next.row       = row_sat ? lesq_pkg::POS_W'(lesq_pkg::MAX_ROWS - 1)
                                  : lesq_pkg::POS_W'(row_pos);
    item_next.first_row = row_pos == '0;
    item_next.row_sat   = row_sat;
    item_next.col_wrap  = (lesq_pkg::CCOUNT_W'(col_pos) + lesq_pkg::CCOUNT_W'(1)) >= cols_eff;
    // the entry being written back this cycle is read stale, so bypass it
    item_next.fwd_hit   = s1_valid && (s1_item.col == col_pos);
  end

  // column and row counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (accept) begin
      if (cell_data.last_cell) begin
        col_pos <= '0;
        row_pos <= '0;
      end else if (item_next.col_wrap) begin
        col_pos <= '0;
        if (!row_sat) begin
          row_pos <= row_pos + lesq_pkg::ROW_CNT_W'(1);
        end
      end else begin
        col_pos <= col_pos + lesq_pkg::COL_W'(1);
      end
    end
  end

  // scoring stage register; forward word captured with it
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item   <= item_next;
      fwd_score <= wr.data;
    end
  end

  lesq_line_buf u_line_buf (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (accept),
    .rd_addr (col_pos),
    .rd_data (up_mem)
  );

  lesq_score u_score (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (s1_valid),
    .item         (s1_item),
    .up_mem       (up_mem),
    .up_fwd       (fwd_score),
    .wr           (wr),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

### rtl/lesq_line_buf.sv
// One-row line buffer of scores: single write port, registered read port.
// Depends on lesq_pkg for depth and score width.
module lesq_line_buf (
  input  logic                          clk,
  input  lesq_pkg::lesq_wr_t            wr,
  input  logic                          rd_en,
  input  logic [lesq_pkg::COL_W-1:0]    rd_addr,
  output logic [lesq_pkg::SCORE_W-1:0]  rd_data
);

  logic [lesq_pkg::SCORE_W-1:0] mem [lesq_pkg::MAX_COLS];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/lesq_score.sv
// Scoring stage: min of up/left/diagonal plus one, best tracking, result register.
// Depends on lesq_pkg; reads the line buffer data and drives its write port.
module lesq_score (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  lesq_pkg::lesq_item_t          item,
  input  logic [lesq_pkg::SCORE_W-1:0]  up_mem,
  input  logic [lesq_pkg::SCORE_W-1:0]  up_fwd,
  output lesq_pkg::lesq_wr_t            wr,
  output logic                          result_valid,
  input  logic                          result_ready,
  output lesq_pkg::result_word_t        result
);

  logic [lesq_pkg::SCORE_W-1:0] left_score;
  logic [lesq_pkg::SCORE_W-1:0] diag_score;
  logic [lesq_pkg::SCORE_W-1:0] best_size;
  logic [lesq_pkg::POS_W-1:0]   best_row;
  logic [lesq_pkg::POS_W-1:0]   best_col;
  logic                         overflow;

  logic [lesq_pkg::SCORE_W-1:0] up;
  logic [lesq_pkg::SCORE_W-1:0] min_ul;
  logic [lesq_pkg::SCORE_W-1:0] min3;
  logic [lesq_pkg::SCORE_W:0]   grown;
  logic [lesq_pkg::SCORE_W-1:0] score;
  logic [lesq_pkg::SCORE_W-1:0] best_size_next;
  logic [lesq_pkg::POS_W-1:0]   best_row_next;
  logic [lesq_pkg::POS_W-1:0]   best_col_next;
  logic                         overflow_next;

  // score of the current cell
  always_comb begin
    up     = item.fwd_hit ? up_fwd : up_mem;
    min_ul = (up < left_score) ? up : left_score;
    min3   = (min_ul < diag_score) ? min_ul : diag_score;
    grown  = {1'b0, min3} + (lesq_pkg::SCORE_W+1)'(1);
    if (item.blocked) begin
      score = '0;
    end else if (item.first_row || (item.col == '0)) begin
      score = lesq_pkg::SCORE_W'(1);
    end else if (grown[lesq_pkg::SCORE_W]) begin
      score = lesq_pkg::SCORE_MAX;
    end else begin
      score = grown[lesq_pkg::SCORE_W-1:0];
    end
  end

  // first strictly larger score wins
  always_comb begin
    best_size_next = best_size;
    best_row_next  = best_row;
    best_col_next  = best_col;
    if (score > best_size) begin
      best_size_next = score;
      best_row_next  = item.row;
      best_col_next  = lesq_pkg::POS_W'(item.col);
    end
    overflow_next = overflow | item.row_sat;
  end

  // line buffer write back
  always_comb begin
    wr.en   = item_valid;
    wr.addr = item.col;
    wr.data = score;
  end

  // neighbor scores and per-map best
  always_ff @(posedge clk) begin
    if (rst) begin
      left_score <= '0;
      diag_score <= '0;
      best_size  <= '0;
      best_row   <= '0;
      best_col   <= '0;
      overflow   <= 1'b0;
    end else if (item_valid) begin
      if (item.col_wrap || item.last) begin
        left_score <= '0;
        diag_score <= '0;
      end else begin
        left_score <= score;
        diag_score <= up;
      end
      if (item.last) begin
        best_size <= '0;
        best_row  <= '0;
        best_col  <= '0;
        overflow  <= 1'b0;
      end else begin
        best_size <= best_size_next;
        best_row  <= best_row_next;
        best_col  <= best_col_next;
        overflow  <= overflow_next;
      end
    end
  end

  // result register; the top level keeps it free when a last cell arrives
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_valid && item.last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item.last) begin
      result.best_size    <= best_size_next;
      result.best_row     <= best_row_next;
      result.best_col     <= best_col_next;
      result.row_overflow <= overflow_next;
    end
  end

endmodule
